// ===== hw/rtl/mnee_pkg.sv =====
// Package for the MIDI note event encoder.
// Holds the command/status types between controller and datapath, byte codes
// and register indexes. No dependencies.
`timescale 1ns / 1ps

package mnee_pkg;

   // Fixed field widths
   localparam int CHAN_W  = 4;
   localparam int TICK_W  = 32;
   localparam int USQ_W   = 24;
   localparam int TPQ_W   = 10;
   localparam int NUMER_W = 33;   // timestamp_ms * 1000 needs 33 bits
   localparam int IDX_W   = 4;

   // Register indexes on the write port
   localparam logic CSR_TICKS_PER_QUARTER = 1'b0;
   localparam logic CSR_US_PER_QUARTER    = 1'b1;

   // Reset values of the registers
   localparam logic [TPQ_W-1:0] TPQ_RESET = 10'd120;
   localparam logic [USQ_W-1:0] USQ_RESET = 24'd500000;

   // MIDI status bytes
   localparam logic [7:0] MIDI_PROG_CHANGE = 8'hC0;
   localparam logic [7:0] MIDI_NOTE_ON     = 8'h90;
   localparam logic [7:0] MIDI_NOTE_OFF    = 8'h80;
   localparam logic [7:0] MIDI_DELTA_ZERO  = 8'h00;

   // Position of an output byte in the event sequence
   localparam logic [IDX_W-1:0] IDX_PC_DELTA = 4'd0;
   localparam logic [IDX_W-1:0] IDX_PC_STAT  = 4'd1;
   localparam logic [IDX_W-1:0] IDX_PC_PROG  = 4'd2;
   localparam logic [IDX_W-1:0] IDX_VLQ4     = 4'd3;
   localparam logic [IDX_W-1:0] IDX_VLQ3     = 4'd4;
   localparam logic [IDX_W-1:0] IDX_VLQ2     = 4'd5;
   localparam logic [IDX_W-1:0] IDX_VLQ1     = 4'd6;
   localparam logic [IDX_W-1:0] IDX_VLQ0     = 4'd7;
   localparam logic [IDX_W-1:0] IDX_STATUS   = 4'd8;
   localparam logic [IDX_W-1:0] IDX_NOTE     = 4'd9;
   localparam logic [IDX_W-1:0] IDX_VEL      = 4'd10;

   // Controller to datapath
   typedef struct packed {
      logic             load_in;     // capture the input beat
      logic             map_rd;      // read the instrument map
      logic             set_chan;    // resolve the channel of this note
      logic             alloc;       // bind a new instrument to the next channel
      logic             div_start;   // start the shared divider
      logic             div_sel;     // 0: tick period, 1: tick value
      logic             period_save; // keep the period quotient
      logic             tick_save;   // form delta and update the channel's last tick
      logic             out_load;    // load an event byte into the output register
      logic             out_err;     // load the error result
      logic [IDX_W-1:0] byte_idx;    // which event byte
   } mnee_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic             inst_bad;    // instrument beyond the map
      logic             inst_known;  // instrument already has a channel
      logic             chan_full;   // no channel left
      logic             div_done;    // divider result ready
      logic             out_free;    // output register can take a byte
      logic [IDX_W-1:0] vlq_start;   // first delta byte position
   } mnee_sts_type;

endpackage

// ===== hw/rtl/mnee_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mnee_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mnee_div.sv =====
// Restoring divider, one quotient bit per cycle, 33-bit dividend by 24-bit divisor.
// Depends on mnee_pkg.
`timescale 1ns / 1ps

module mnee_div
   import mnee_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUMER_W-1:0] dividend,
   input  logic [USQ_W-1:0]   divisor,
   output logic [NUMER_W-1:0] quotient,
   output logic               done
);

   localparam int CNT_W = $clog2(NUMER_W + 1);

   logic [USQ_W-1:0]   den_ff;
   logic [USQ_W-1:0]   rem_ff, rem_in;
   logic [NUMER_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [USQ_W:0]     shifted;
   logic [USQ_W+1:0]   trial;
   logic               fits;

   // One subtract-and-compare step
   assign shifted = {rem_ff, quo_ff[NUMER_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = !trial[USQ_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(NUMER_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[USQ_W-1:0] : shifted[USQ_W-1:0];
         quo_in = {quo_ff[NUMER_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== hw/rtl/mnee_ctrl.sv =====
// Sequencing controller: map lookup, channel binding, two divisions, byte or error emission.
// Depends on mnee_pkg.
`timescale 1ns / 1ps

module mnee_ctrl
   import mnee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  mnee_sts_type sts,
   output mnee_cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_CHK   = 4'd2;
   localparam logic [3:0] S_DIV1  = 4'd3;
   localparam logic [3:0] S_DIV2S = 4'd4;
   localparam logic [3:0] S_DIV2  = 4'd5;
   localparam logic [3:0] S_TICK  = 4'd6;
   localparam logic [3:0] S_PREP  = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;
   localparam logic [3:0] S_ERR   = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             new_ff, new_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      new_in       = new_ff;
      cmd          = '0;
      cmd.byte_idx = idx_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_RD;
            end
         end
         S_RD: begin
            cmd.map_rd = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (sts.inst_bad || (!sts.inst_known && sts.chan_full)) begin
               state_in = S_ERR;
            end else begin
               cmd.set_chan  = 1'b1;
               cmd.alloc     = !sts.inst_known;
               new_in        = !sts.inst_known;
               cmd.div_start = 1'b1;
               state_in      = S_DIV1;
            end
         end
         S_DIV1: begin
            if (sts.div_done) begin
               cmd.period_save = 1'b1;
               state_in        = S_DIV2S;
            end
         end
         S_DIV2S: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in      = S_DIV2;
         end
         S_DIV2: begin
            if (sts.div_done) begin
               cmd.tick_save = 1'b1;
               state_in      = S_TICK;
            end
         end
         S_TICK: begin
            state_in = S_PREP;
         end
         S_PREP: begin
            idx_in   = new_ff ? IDX_PC_DELTA : sts.vlq_start;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (idx_ff == IDX_VEL) begin
                  state_in = S_IDLE;
               end else if (idx_ff == IDX_PC_PROG) begin
                  idx_in = sts.vlq_start;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.out_err = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= IDX_PC_DELTA;
         new_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         new_ff   <= new_in;
      end
   end

endmodule

// ===== hw/rtl/mnee_dpath.sv =====
// Datapath: input capture, config registers, instrument map, tick arithmetic,
// per-channel last tick, byte formatting and the output register.
// Depends on mnee_pkg, mnee_ram and mnee_div.
`timescale 1ns / 1ps

module mnee_dpath
   import mnee_pkg::*;
#(
   parameter int NUM_CHANNELS    = 16,
   parameter int NUM_INSTRUMENTS = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  mnee_cmd_type       cmd,
   output mnee_sts_type       sts,
   input  logic [6:0]         instrument,
   input  logic [22:0]        timestamp_ms,
   input  logic               note_on,
   input  logic [6:0]         note_value,
   input  logic [6:0]         velocity,
   input  logic               csr_we,
   input  logic               csr_addr,
   input  logic [USQ_W-1:0]   csr_wdata,
   output logic [7:0]         out_byte,
   output logic [CHAN_W-1:0]  channel,
   output logic               last_byte,
   output logic               error,
   output logic               rsp_tvalid,
   input  logic               rsp_tready
);

   localparam int IAW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
   localparam int CAW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Captured input beat
   logic [6:0]  instr_ff;
   logic [22:0] ts_ff;
   logic        on_ff;
   logic [6:0]  note_ff;
   logic [6:0]  vel_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         instr_ff <= instrument;
         ts_ff    <= timestamp_ms;
         on_ff    <= note_on;
         note_ff  <= note_value;
         vel_ff   <= velocity;
      end
   end

   // Configuration registers
   logic [TPQ_W-1:0] tpq_ff;
   logic [USQ_W-1:0] usq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpq_ff <= TPQ_RESET;
         usq_ff <= USQ_RESET;
      end else if (csr_we) begin
         if (csr_addr == CSR_TICKS_PER_QUARTER) begin
            tpq_ff <= csr_wdata[TPQ_W-1:0];
         end
         if (csr_addr == CSR_US_PER_QUARTER) begin
            usq_ff <= csr_wdata;
         end
      end
   end

   // Instrument map: valid bits in flops, channel numbers in RAM
   logic [NUM_INSTRUMENTS-1:0] map_vld_ff;
   logic [4:0]                 used_ff;
   logic [CHAN_W-1:0]          map_chan;
   logic [IAW-1:0]             inst_idx;

   assign inst_idx = instr_ff[IAW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
         used_ff    <= '0;
      end else if (cmd.alloc) begin
         map_vld_ff[inst_idx] <= 1'b1;
         used_ff              <= used_ff + 1'b1;
      end
   end

   mnee_ram #(
      .WIDTH (CHAN_W),
      .DEPTH (NUM_INSTRUMENTS)
   ) u_map (
      .clock   (clock),
      .wr_en   (cmd.alloc),
      .wr_addr (inst_idx),
      .wr_data (used_ff[CHAN_W-1:0]),
      .rd_en   (cmd.map_rd),
      .rd_addr (inst_idx),
      .rd_data (map_chan)
   );

   // Channel of the current note
   logic [CHAN_W-1:0] ch_ff;

   always_ff @(posedge clock) begin
      if (cmd.set_chan) begin
         ch_ff <= map_vld_ff[inst_idx] ? map_chan : used_ff[CHAN_W-1:0];
      end
   end

   // Shared divider: first the tick period, then the tick value
   logic [TPQ_W-1:0]   tpq_eff;
   logic [NUMER_W-1:0] ts_scaled;
   logic [NUMER_W-1:0] div_num;
   logic [USQ_W-1:0]   div_den;
   logic [NUMER_W-1:0] div_quo;
   logic [USQ_W-1:0]   period_ff;

   assign tpq_eff   = (tpq_ff == '0) ? TPQ_W'(1) : tpq_ff;
   assign ts_scaled = NUMER_W'(ts_ff) * NUMER_W'(1000);
   assign div_num   = cmd.div_sel ? ts_scaled : NUMER_W'(usq_ff);
   assign div_den   = cmd.div_sel ? period_ff : USQ_W'(tpq_eff);

   mnee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .done     (sts.div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.period_save) begin
         period_ff <= div_quo[USQ_W-1:0];
      end
   end

   // Tick, delta and the per-channel last tick
   logic [TICK_W-1:0] last_tick_ff [NUM_CHANNELS];
   logic [TICK_W-1:0] tick;
   logic [TICK_W-1:0] delta_ff;
   logic [CAW-1:0]    ch_idx;

   assign ch_idx = ch_ff[CAW-1:0];
   assign tick   = (period_ff == '0) ? '1 : div_quo[TICK_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_tick_ff[i] <= '0;
         end
      end else if (cmd.alloc) begin
         last_tick_ff[used_ff[CAW-1:0]] <= '0;
      end else if (cmd.tick_save) begin
         last_tick_ff[ch_idx] <= tick;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_save) begin
         delta_ff <= tick - last_tick_ff[ch_idx];
      end
   end

   // First byte of the variable-length delta
   logic [IDX_W-1:0] vlq_start;

   always_comb begin
      if (delta_ff[31:28] != '0) begin
         vlq_start = IDX_VLQ4;
      end else if (delta_ff[27:21] != '0) begin
         vlq_start = IDX_VLQ3;
      end else if (delta_ff[20:14] != '0) begin
         vlq_start = IDX_VLQ2;
      end else if (delta_ff[13:7] != '0) begin
         vlq_start = IDX_VLQ1;
      end else begin
         vlq_start = IDX_VLQ0;
      end
   end

   // Event byte for the current position
   logic [7:0] ev_byte;

   always_comb begin
      unique case (cmd.byte_idx)
         IDX_PC_DELTA: ev_byte = MIDI_DELTA_ZERO;
         IDX_PC_STAT:  ev_byte = MIDI_PROG_CHANGE | {4'h0, ch_ff};
         IDX_PC_PROG:  ev_byte = {1'b0, instr_ff};
         IDX_VLQ4:     ev_byte = {4'h8, delta_ff[31:28]};
         IDX_VLQ3:     ev_byte = {1'b1, delta_ff[27:21]};
         IDX_VLQ2:     ev_byte = {1'b1, delta_ff[20:14]};
         IDX_VLQ1:     ev_byte = {1'b1, delta_ff[13:7]};
         IDX_VLQ0:     ev_byte = {1'b0, delta_ff[6:0]};
         IDX_STATUS:   ev_byte = (on_ff ? MIDI_NOTE_ON : MIDI_NOTE_OFF) | {4'h0, ch_ff};
         IDX_NOTE:     ev_byte = {1'b0, note_ff};
         IDX_VEL:      ev_byte = {1'b0, vel_ff};
         default:      ev_byte = '0;
      endcase
   end

   // Output register
   logic [7:0]        rsp_byte_ff;
   logic [CHAN_W-1:0] rsp_chan_ff;
   logic              rsp_last_ff;
   logic              rsp_err_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load || cmd.out_err) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_err) begin
         rsp_byte_ff <= '0;
         rsp_chan_ff <= '0;
         rsp_last_ff <= 1'b1;
         rsp_err_ff  <= 1'b1;
      end else if (cmd.out_load) begin
         rsp_byte_ff <= ev_byte;
         rsp_chan_ff <= ch_ff;
         rsp_last_ff <= (cmd.byte_idx == IDX_VEL);
         rsp_err_ff  <= 1'b0;
      end
   end

   assign out_byte   = rsp_byte_ff;
   assign channel    = rsp_chan_ff;
   assign last_byte  = rsp_last_ff;
   assign error      = rsp_err_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // Status to the controller
   assign sts.inst_bad   = ({1'b0, instr_ff} >= 8'(NUM_INSTRUMENTS));
   assign sts.inst_known = map_vld_ff[inst_idx];
   assign sts.chan_full  = (used_ff >= 5'(NUM_CHANNELS));
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;
   assign sts.vlq_start  = vlq_start;

endmodule

// ===== hw/rtl/midi_note_event_encoder_core.sv =====
// MIDI note event encoder: each note beat in gives a run of track bytes out;
// the first note of an instrument binds it to the next free channel and emits
// a program change. req_tdata, from bit 0: instrument[7], timestamp_ms[23],
// note_value[7], velocity[7], zero pad to 48 bits; req_tuser is note_on.
// rsp_tdata, from bit 0: out_byte[8], channel[4], zero pad to 16 bits;
// rsp_tlast marks the final byte of a note, rsp_tuser flags the error result
// (an instrument beyond the map, or a new instrument with no channel left),
// which is a single beat. Registers: index 0 ticks_per_quarter, index 1
// us_per_quarter; the user must see they are written only while idle, as the
// block does not enforce it. Timing: one note at a time. After acceptance the
// map is read and checked, then two 33-step divisions run on one shared
// bit-serial divider (period, then tick value), the first delta byte is
// picked, and then one byte per cycle goes out while the receiver is ready,
// 4 to 11 bytes. The next note is accepted only after the last byte or the
// error result is loaded into the output register. When the receiver stalls,
// the output register holds its beat and the byte sequence waits. Reset
// clears the instrument map, the channel count and every channel's last
// tick, and restores the register defaults.
// Depends on mnee_pkg, mnee_ctrl, mnee_dpath.
`timescale 1ns / 1ps

module midi_note_event_encoder_core
   import mnee_pkg::*;
#(
   parameter int NUM_CHANNELS    = 16,
   parameter int NUM_INSTRUMENTS = 128
) (
   input  logic             clock,
   input  logic             reset,
   // note beats in
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [47:0]      req_tdata,  // instrument, timestamp_ms, note_value, velocity
   input  logic             req_tuser,  // note_on
   // track bytes out
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,  // out_byte, channel
   output logic             rsp_tlast,  // last_byte
   output logic             rsp_tuser,  // error
   // register writes
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [USQ_W-1:0] csr_wdata
);

   mnee_cmd_type      cmd;
   mnee_sts_type      sts;
   logic [7:0]        out_byte;
   logic [CHAN_W-1:0] channel;

   mnee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mnee_dpath #(
      .NUM_CHANNELS    (NUM_CHANNELS),
      .NUM_INSTRUMENTS (NUM_INSTRUMENTS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .instrument   (req_tdata[6:0]),
      .timestamp_ms (req_tdata[29:7]),
      .note_on      (req_tuser),
      .note_value   (req_tdata[36:30]),
      .velocity     (req_tdata[43:37]),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .out_byte     (out_byte),
      .channel      (channel),
      .last_byte    (rsp_tlast),
      .error        (rsp_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready)
   );

   assign rsp_tdata = {4'h0, channel, out_byte};

endmodule
